/* design/ufr_pkg.sv */
// Shared types, codes and constants of the update frame receiver.
// Used by ufr_ctrl, ufr_dpath and the top level; depends on nothing.
`timescale 1ns / 1ps

package ufr_pkg;

  localparam int unsigned STORE_BYTES_DEF = 256;
  localparam int unsigned RESULT_CAP = 63;
  localparam int unsigned FRAME_OVH = 7;
  localparam int unsigned AUX_POS = 5;
  localparam int unsigned WORD_POS = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_CODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_BASE = 3'd5;

  localparam logic [7:0] HEADER_FIRST_RST = 8'h55;
  localparam logic [7:0] HEADER_SECOND_RST = 8'hAA;
  localparam logic [7:0] START_CODE_RST = 8'h01;
  localparam logic [7:0] DATA_CODE_RST = 8'h02;
  localparam logic [7:0] END_CODE_RST = 8'h03;

  localparam logic [2:0] KIND_WORD = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_ACK = 3'd2;
  localparam logic [2:0] KIND_END = 3'd3;
  localparam logic [2:0] KIND_CRC_ERR = 3'd4;
  localparam logic [2:0] KIND_SLEN_ERR = 3'd5;
  localparam logic [2:0] KIND_DLEN_ERR = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN = 3'd7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SAVE_H0,
    OP_DROP,
    OP_SAVE_CMD,
    OP_SAVE_L0,
    OP_SAVE_L1,
    OP_CRC_INIT,
    OP_CRC_STEP,
    OP_SAVE_R0,
    OP_SAVE_R1,
    OP_AUX_STEP,
    OP_DECIDE,
    OP_PUT_RES,
    OP_WORD_START,
    OP_WORD_STEP,
    OP_PUT_WORD,
    OP_PUT_ACK,
    OP_CONSUME,
    OP_FLUSH
  } ufr_op_e;

  typedef enum logic [1:0] {
    RS_FIX,
    RS_NEXT,
    RS_CRCHI,
    RS_WSTART
  } ufr_rsel_e;

  typedef struct packed {
    ufr_op_e   op;
    logic      rd_en;
    ufr_rsel_e rd_sel;
    logic [3:0] rd_fix;
  } ufr_cmd_t;

  typedef struct packed {
    logic fill_full;
    logic fill_lt7;
    logic hdr_ok;
    logic frame_short;
    logic crc_end;
    logic byte_last;
    logic path_words;
    logic path_ack;
    logic words_end;
    logic nres_cap;
    logic can_put;
    logic out_free;
    logic pend_v;
  } ufr_stat_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [31:0] val;
    logic [31:0] tot;
    logic        last;
  } ufr_res_t;

endpackage

/* design/ufr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
`timescale 1ns / 1ps

module ufr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ufr_ctrl.sv */
// Sequencer of the update frame receiver: steps the datapath through byte
// intake, header scan, CRC check and result emission. Uses ufr_pkg.
`timescale 1ns / 1ps

module ufr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ufr_pkg::ufr_stat_t stat_i,
  output ufr_pkg::ufr_cmd_t  cmd_o
);
  import ufr_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE  = 20'h00001,
    ST_CHECK = 20'h00002,
    ST_H0    = 20'h00004,
    ST_H1    = 20'h00008,
    ST_CMD   = 20'h00010,
    ST_L0    = 20'h00020,
    ST_L1    = 20'h00040,
    ST_LEN   = 20'h00080,
    ST_CRC   = 20'h00100,
    ST_R0    = 20'h00200,
    ST_R1    = 20'h00400,
    ST_AUX   = 20'h00800,
    ST_DEC   = 20'h01000,
    ST_WRD   = 20'h02000,
    ST_WBY   = 20'h04000,
    ST_WPUT  = 20'h08000,
    ST_ACK   = 20'h10000,
    ST_EMIT  = 20'h20000,
    ST_CONS  = 20'h40000,
    ST_FLUSH = 20'h80000
  } ufr_state_e;

  ufr_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d = stat_i.fill_full ? ST_IDLE : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.fill_lt7) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_fix = 4'd0;
          state_d = ST_H0;
        end
      end
      ST_H0: begin
        cmd_o.op = OP_SAVE_H0;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_fix = 4'd1;
        state_d = ST_H1;
      end
      ST_H1: begin
        if (stat_i.hdr_ok) begin
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_fix = 4'd2;
          state_d = ST_CMD;
        end else begin
          cmd_o.op = OP_DROP;
          state_d = ST_CHECK;
        end
      end
      ST_CMD: begin
        cmd_o.op = OP_SAVE_CMD;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_fix = 4'd3;
        state_d = ST_L0;
      end
      ST_L0: begin
        cmd_o.op = OP_SAVE_L0;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_fix = 4'd4;
        state_d = ST_L1;
      end
      ST_L1: begin
        cmd_o.op = OP_SAVE_L1;
        state_d = ST_LEN;
      end
      ST_LEN: begin
        if (stat_i.frame_short) begin
          state_d = ST_FLUSH;
        end else begin
          cmd_o.op = OP_CRC_INIT;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_fix = 4'd0;
          state_d = ST_CRC;
        end
      end
      ST_CRC: begin
        cmd_o.op = OP_CRC_STEP;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RS_NEXT;
        if (stat_i.crc_end) begin
          state_d = ST_R0;
        end
      end
      ST_R0: begin
        cmd_o.op = OP_SAVE_R0;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RS_CRCHI;
        state_d = ST_R1;
      end
      ST_R1: begin
        cmd_o.op = OP_SAVE_R1;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_fix = 4'(AUX_POS);
        state_d = ST_AUX;
      end
      ST_AUX: begin
        cmd_o.op = OP_AUX_STEP;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RS_NEXT;
        if (stat_i.byte_last) begin
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        cmd_o.op = OP_DECIDE;
        if (stat_i.path_words) begin
          state_d = ST_WRD;
        end else if (stat_i.path_ack) begin
          state_d = ST_ACK;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_WRD: begin
        if (stat_i.nres_cap) begin
          state_d = ST_ACK;
        end else begin
          cmd_o.op = OP_WORD_START;
          cmd_o.rd_en = 1'b1;
          cmd_o.rd_sel = RS_WSTART;
          state_d = ST_WBY;
        end
      end
      ST_WBY: begin
        cmd_o.op = OP_WORD_STEP;
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_sel = RS_NEXT;
        if (stat_i.byte_last) begin
          state_d = ST_WPUT;
        end
      end
      ST_WPUT: begin
        if (stat_i.can_put) begin
          cmd_o.op = OP_PUT_WORD;
          state_d = stat_i.words_end ? ST_ACK : ST_WRD;
        end
      end
      ST_ACK: begin
        if (stat_i.can_put) begin
          cmd_o.op = OP_PUT_ACK;
          state_d = ST_CONS;
        end
      end
      ST_EMIT: begin
        if (stat_i.can_put) begin
          cmd_o.op = OP_PUT_RES;
          state_d = ST_CONS;
        end
      end
      ST_CONS: begin
        cmd_o.op = OP_CONSUME;
        state_d = ST_CHECK;
      end
      ST_FLUSH: begin
        if (!stat_i.pend_v) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.op = OP_FLUSH;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/ufr_dpath.sv */
// Datapath of the update frame receiver: circular frame store, registers,
// CRC unit, word assembly and the result registers. Uses ufr_pkg, ufr_ram.
`timescale 1ns / 1ps

module ufr_dpath #(
  parameter int unsigned STORE_BYTES = ufr_pkg::STORE_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ufr_pkg::ufr_cmd_t              cmd_i,
  output ufr_pkg::ufr_stat_t             stat_o,
  input  logic [7:0]                     rx_byte_i,
  input  logic                           cfg_valid_i,
  input  logic [ufr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output ufr_pkg::ufr_res_t              out_o
);
  import ufr_pkg::*;

  localparam int unsigned AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int unsigned OW = AW + 1;
  localparam logic [OW-1:0] STORE_W = OW'(STORE_BYTES);

  function automatic logic [AW-1:0] wrap_addr(logic [AW-1:0] base, logic [OW-1:0] off);
    logic [OW:0] s;
    s = (OW + 1)'(base) + (OW + 1)'(off);
    if (s >= (OW + 1)'(STORE_BYTES)) begin
      s = s - (OW + 1)'(STORE_BYTES);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [15:0] crc_byte(logic [15:0] c_in, logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Configuration registers.
  logic [7:0]  hdr_first_q, hdr_second_q, start_code_q, data_code_q, end_code_q;
  logic [31:0] base_q;

  // Control state.
  logic [AW-1:0] head_q, head_d;
  logic [OW-1:0] fill_q, fill_d;
  logic [31:0]   total_q, total_d;
  logic [15:0]   crc_q, crc_d;
  logic [5:0]    nres_q, nres_d;
  logic          pend_v_q, pend_v_d;
  logic          out_v_q, out_v_d;

  // Payload registers.
  logic          ok0_q, ok0_d;
  logic [7:0]    cmd_q, cmd_d;
  logic [15:0]   dlen_q, dlen_d;
  logic [15:0]   recv_q, recv_d;
  logic [31:0]   aux_q, aux_d;
  logic [OW-1:0] idx_q, idx_d;
  logic [OW-1:0] wi_q, wi_d;
  logic [31:0]   word_q, word_d;
  logic [31:0]   addr_q, addr_d;
  logic [2:0]    rkind_q, rkind_d;
  logic [31:0]   rval_q, rval_d;
  ufr_res_t      pend_q, pend_d;
  ufr_res_t      out_q, out_d;

  logic [7:0]    rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [OW-1:0] rd_off;

  logic [16:0]   plen;
  logic [OW-1:0] plen_o;
  logic [15:0]   fw_len;
  logic [OW-1:0] fw_o;
  logic          crc_bad, is_start, is_data, is_end, data_ok;
  logic          out_free;
  logic          put_en;
  ufr_res_t      put_r;
  logic [7:0]    wbyte;

  assign plen   = {1'b0, dlen_q} + 17'(FRAME_OVH);
  assign plen_o = plen[OW-1:0];
  assign fw_len = dlen_q - 16'd4;
  assign fw_o   = fw_len[OW-1:0];

  assign crc_bad  = (crc_q != recv_q);
  assign is_start = (cmd_q == start_code_q);
  assign is_data  = (cmd_q == data_code_q);
  assign is_end   = (cmd_q == end_code_q);
  assign data_ok  = !crc_bad && !is_start && is_data && (dlen_q >= 16'd4);
  assign out_free = !out_v_q || !out_stall_i;
  assign wbyte    = (idx_q < (plen_o - OW'(2))) ? rdata : 8'h00;

  always_comb begin
    stat_o.fill_full   = (fill_q == STORE_W);
    stat_o.fill_lt7    = (fill_q < OW'(FRAME_OVH));
    stat_o.hdr_ok      = ok0_q && (rdata == hdr_second_q);
    stat_o.frame_short = (17'(fill_q) < plen);
    stat_o.crc_end     = ((idx_q + OW'(1)) == (plen_o - OW'(2)));
    stat_o.byte_last   = (idx_q[1:0] == 2'b00);
    stat_o.path_words  = data_ok && (dlen_q != 16'd4);
    stat_o.path_ack    = data_ok && (dlen_q == 16'd4);
    stat_o.words_end   = ((wi_q + OW'(4)) >= fw_o);
    stat_o.nres_cap    = (nres_q >= 6'(RESULT_CAP - 1));
    stat_o.can_put     = !pend_v_q || out_free;
    stat_o.out_free    = out_free;
    stat_o.pend_v      = pend_v_q;
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RS_FIX:    rd_off = OW'(cmd_i.rd_fix);
      RS_NEXT:   rd_off = idx_q + OW'(1);
      RS_CRCHI:  rd_off = plen_o - OW'(1);
      RS_WSTART: rd_off = OW'(WORD_POS) + wi_q;
      default:   rd_off = '0;
    endcase
  end

  assign ram_raddr = wrap_addr(head_q, rd_off);
  assign ram_waddr = wrap_addr(head_q, fill_q);
  assign ram_we    = (cmd_i.op == OP_ACCEPT) && (fill_q != STORE_W);

  ufr_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(rx_byte_i),
    .re_i   (cmd_i.rd_en),
    .raddr_i(ram_raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    total_d  = total_q;
    crc_d    = crc_q;
    nres_d   = nres_q;
    ok0_d    = ok0_q;
    cmd_d    = cmd_q;
    dlen_d   = dlen_q;
    recv_d   = recv_q;
    aux_d    = aux_q;
    idx_d    = idx_q;
    wi_d     = wi_q;
    word_d   = word_q;
    addr_d   = addr_q;
    rkind_d  = rkind_q;
    rval_d   = rval_q;
    put_en   = 1'b0;
    put_r    = '0;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    out_v_d  = out_v_q && out_stall_i;

    unique case (cmd_i.op)
      OP_NONE: ;
      OP_ACCEPT: begin
        nres_d = '0;
        if (fill_q == STORE_W) begin
          fill_d = '0;
        end else begin
          fill_d = fill_q + OW'(1);
        end
      end
      OP_SAVE_H0:  ok0_d = (rdata == hdr_first_q);
      OP_DROP: begin
        head_d = wrap_addr(head_q, OW'(1));
        fill_d = fill_q - OW'(1);
      end
      OP_SAVE_CMD: cmd_d = rdata;
      OP_SAVE_L0:  dlen_d[7:0] = rdata;
      OP_SAVE_L1:  dlen_d[15:8] = rdata;
      OP_CRC_INIT: begin
        crc_d = CRC_INIT;
        idx_d = '0;
      end
      OP_CRC_STEP: begin
        crc_d = crc_byte(crc_q, rdata);
        idx_d = idx_q + OW'(1);
      end
      OP_SAVE_R0:  recv_d[7:0] = rdata;
      OP_SAVE_R1: begin
        recv_d[15:8] = rdata;
        idx_d = OW'(AUX_POS);
      end
      OP_AUX_STEP: begin
        aux_d = {rdata, aux_q[31:8]};
        idx_d = idx_q + OW'(1);
      end
      OP_DECIDE: begin
        addr_d = base_q + aux_q;
        wi_d = '0;
        rval_d = '0;
        if (crc_bad) begin
          rkind_d = KIND_CRC_ERR;
        end else if (is_start) begin
          if (dlen_q != 16'd4) begin
            rkind_d = KIND_SLEN_ERR;
            rval_d = {16'h0000, dlen_q};
          end else begin
            rkind_d = KIND_START;
            rval_d = aux_q;
            total_d = '0;
          end
        end else if (is_data) begin
          rkind_d = KIND_DLEN_ERR;
          rval_d = {16'h0000, dlen_q};
        end else if (is_end) begin
          rkind_d = KIND_END;
        end else begin
          rkind_d = KIND_UNKNOWN;
          rval_d = {24'h000000, cmd_q};
        end
      end
      OP_PUT_RES: begin
        put_en = 1'b1;
        put_r.kind = rkind_q;
        put_r.val = rval_q;
        put_r.tot = total_q;
      end
      OP_WORD_START: idx_d = OW'(WORD_POS) + wi_q;
      OP_WORD_STEP: begin
        word_d = {wbyte, word_q[31:8]};
        idx_d = idx_q + OW'(1);
      end
      OP_PUT_WORD: begin
        put_en = 1'b1;
        put_r.kind = KIND_WORD;
        put_r.addr = addr_q;
        put_r.val = word_q;
        put_r.tot = total_q;
        addr_d = addr_q + 32'd4;
        wi_d = wi_q + OW'(4);
      end
      OP_PUT_ACK: begin
        total_d = total_q + {16'h0000, fw_len};
        put_en = 1'b1;
        put_r.kind = KIND_ACK;
        put_r.val = {16'h0000, fw_len};
        put_r.tot = total_q + {16'h0000, fw_len};
      end
      OP_CONSUME: begin
        head_d = wrap_addr(head_q, plen_o);
        fill_d = fill_q - plen_o;
      end
      OP_FLUSH: begin
        out_d = pend_q;
        out_d.last = 1'b1;
        out_v_d = 1'b1;
        pend_v_d = 1'b0;
      end
      default: ;
    endcase

    // The newest result waits in the pending slot until the next one shows
    // whether it is the last result of this byte.
    if (put_en && (nres_q != 6'(RESULT_CAP))) begin
      nres_d = nres_q + 6'd1;
      pend_d = put_r;
      pend_v_d = 1'b1;
      if (pend_v_q) begin
        out_d = pend_q;
        out_d.last = 1'b0;
        out_v_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      fill_q   <= '0;
      total_q  <= '0;
      crc_q    <= CRC_INIT;
      nres_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      head_q   <= head_d;
      fill_q   <= fill_d;
      total_q  <= total_d;
      crc_q    <= crc_d;
      nres_q   <= nres_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ok0_q   <= ok0_d;
    cmd_q   <= cmd_d;
    dlen_q  <= dlen_d;
    recv_q  <= recv_d;
    aux_q   <= aux_d;
    idx_q   <= idx_d;
    wi_q    <= wi_d;
    word_q  <= word_d;
    addr_q  <= addr_d;
    rkind_q <= rkind_d;
    rval_q  <= rval_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HEADER_FIRST_RST;
      hdr_second_q <= HEADER_SECOND_RST;
      start_code_q <= START_CODE_RST;
      data_code_q  <= DATA_CODE_RST;
      end_code_q   <= END_CODE_RST;
      base_q       <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HEADER_FIRST:   hdr_first_q <= cfg_data_i[7:0];
        CFG_HEADER_SECOND:  hdr_second_q <= cfg_data_i[7:0];
        CFG_START_CODE:     start_code_q <= cfg_data_i[7:0];
        CFG_DATA_CODE:      data_code_q <= cfg_data_i[7:0];
        CFG_END_CODE:       end_code_q <= cfg_data_i[7:0];
        CFG_PARTITION_BASE: base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o = out_q;

endmodule

/* design/update_frame_receiver.sv */
// Top level of the update frame receiver: sequencer plus datapath.
// Uses ufr_pkg, ufr_ctrl, ufr_dpath (which holds the ufr_ram frame store).
`timescale 1ns / 1ps

// The receiver takes one link byte per item into a circular frame store and
// looks for frames of the form header, header, command, 16-bit little-endian
// length, payload, CRC-16/Modbus (low byte first). Leading bytes that do not
// form a header are dropped one at a time once seven bytes are held. A byte
// that completes a frame also runs the CRC unit over the store at one byte
// per cycle, as the store has a single read port, then emits the results of
// that frame; output stalls can hold each of these results.
// Results leave through an output register, and the next byte is taken only
// once the results of the last one are in or beyond that register.
// The store needs no clearing after reset; a byte arriving at a full store
// empties it and is dropped without any result. Configuration writes are
// accepted at any time (ready is always high) and are meant to be issued
// while the block is idle.
module update_frame_receiver #(
  parameter int unsigned STORE_BYTES = ufr_pkg::STORE_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    kind_o,
  output logic [31:0]                   flash_address_o,
  output logic [31:0]                   payload_value_o,
  output logic [31:0]                   received_total_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ufr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);
  import ufr_pkg::*;

  ufr_cmd_t  cmd;
  ufr_stat_t stat;
  ufr_res_t  res;

  // Registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  ufr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  ufr_dpath #(
    .STORE_BYTES(STORE_BYTES)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .rx_byte_i  (rx_byte_i),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_o      (res)
  );

  assign kind_o           = res.kind;
  assign flash_address_o  = res.addr;
  assign payload_value_o  = res.val;
  assign received_total_o = res.tot;
  assign last_o           = res.last;

  // A byte accepted into a store with room always starts a busy period; a
  // byte arriving at a full store is dropped and leaves the block idle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !stat.fill_full) |=> in_stall_o)
    else $error("receiver took a byte without going busy");

  // Back in idle, no result may still sit in the pending slot.
  a_no_pending_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !stat.pend_v)
    else $error("result left pending while idle");

  // Only flash words carry an address.
  a_addr_words_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_WORD)) |-> (flash_address_o == 32'd0))
    else $error("non-word result carries a flash address");

endmodule
